// ----- design/dtq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_ARM     = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNARMED = 2'd1;
    localparam logic [1:0] ST_FIRED   = 2'd2;

    // Classified operations handed from front to back
    localparam logic [1:0] OP_ARM     = 2'd0;
    localparam logic [1:0] OP_CANCEL  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam int ID_W     = 4;
    localparam int FIELD_W  = 32;
    localparam int MAX_FIRES = 16;
    localparam int CNT_W    = 5;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic               id_ok;
        logic [FIELD_W-1:0] tval;
    } dtq_item_t;

endpackage

`default_nettype wire

// ----- design/dtq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/dtq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtq_front
    import dtq_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic [ID_W-1:0]    timer_id,
    input  wire logic [FIELD_W-1:0] deadline,
    input  wire logic [FIELD_W-1:0] now_time,
    output logic                    q_valid,
    output dtq_item_t               q_item,
    input  wire logic               q_pop
);

    dtq_item_t  slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    dtq_item_t  cls;
    logic       push;

    // Classify: decode the op, check the slot range, keep only the time that matters
    always_comb
    begin
        cls.id    = timer_id;
        cls.id_ok = (32'(timer_id) < ENTRIES);
        cls.tval  = (command == CMD_ARM) ? deadline : now_time;
        case (command)
            CMD_ARM:     cls.op = OP_ARM;
            CMD_CANCEL:  cls.op = OP_CANCEL;
            CMD_ADVANCE: cls.op = OP_ADVANCE;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ q_pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/dtq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtq_back
    import dtq_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  dtq_item_t               q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ID_W-1:0]         fired_id,
    output logic [1:0]              status,
    output logic                    last,
    output logic                    any_armed,
    output logic [FIELD_W-1:0]      nearest_deadline
);

    localparam int IW = $clog2(ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ENTRIES-1:0]   armed_reg, armed_next;
    logic [IW:0]          addr_reg, addr_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 best_any_reg, best_any_next;
    logic [IW-1:0]        best_id_reg, best_id_next;
    logic [TIME_BITS-1:0] best_val_reg, best_val_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 fired_reg, fired_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [1:0]           res_st_reg, res_st_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      o_id_reg, o_id_next;
    logic [1:0]           o_st_reg, o_st_next;
    logic                 o_last_reg, o_last_next;
    logic                 o_any_reg, o_any_next;
    logic [FIELD_W-1:0]   o_near_reg, o_near_next;

    logic                 rd_en;
    logic [TIME_BITS-1:0] rdata;
    logic                 ram_we;
    logic [IW-1:0]        q_idx;
    logic                 cand;
    logic                 scan_done;
    logic                 due;
    logic                 more;
    logic                 load;
    logic                 do_fire;

    assign q_idx  = IW'(q_item.id);
    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign ram_we = q_pop && (q_item.op == OP_ARM) && q_item.id_ok;
    assign rd_en  = (state_reg == S_SCAN) && (addr_reg < (IW+1)'(ENTRIES));

    dtq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (ENTRIES)
    ) u_wake (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_idx),
        .wdata (TIME_BITS'(q_item.tval)),
        .re    (rd_en),
        .raddr (addr_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign cand      = pend_reg && armed_reg[idx_reg]
                       && (!best_any_reg || (rdata < best_val_reg));
    assign scan_done = pend_reg && (idx_reg == IW'(ENTRIES - 1));
    assign due       = best_any_reg && (best_val_reg <= now_reg);
    assign more      = fired_reg && due && (count_reg < CNT_W'(MAX_FIRES));
    assign load      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign do_fire   = ((state_reg == S_DECIDE) && (op_reg == OP_ADVANCE)
                        && !fired_reg && due)
                       || (load && more);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        now_next      = now_reg;
        armed_next    = armed_reg;
        addr_next     = addr_reg;
        pend_next     = rd_en;
        idx_next      = addr_reg[IW-1:0];
        best_any_next = best_any_reg;
        best_id_next  = best_id_reg;
        best_val_next = best_val_reg;
        count_next    = count_reg;
        fired_next    = fired_reg;
        res_id_next   = res_id_reg;
        res_st_next   = res_st_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    op_next       = q_item.op;
                    now_next      = TIME_BITS'(q_item.tval);
                    count_next    = '0;
                    fired_next    = 1'b0;
                    res_id_next   = q_item.id;
                    res_st_next   = ST_OK;
                    addr_next     = '0;
                    best_any_next = 1'b0;
                    state_next    = S_SCAN;
                    case (q_item.op)
                        OP_ARM:
                        begin
                            if (q_item.id_ok)
                            begin
                                armed_next[q_idx] = 1'b1;
                            end
                            else
                            begin
                                res_st_next = ST_UNARMED;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (q_item.id_ok && armed_reg[q_idx])
                            begin
                                armed_next[q_idx] = 1'b0;
                            end
                            else
                            begin
                                res_st_next = ST_UNARMED;
                            end
                        end
                        default:
                        begin
                            res_id_next = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (cand)
                begin
                    best_any_next = 1'b1;
                    best_id_next  = idx_reg;
                    best_val_next = rdata;
                end
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load && !more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fire the earliest due timer, then rescan for the new minimum
        if (do_fire)
        begin
            armed_next[best_id_reg] = 1'b0;
            res_id_next   = ID_W'(best_id_reg);
            count_next    = count_reg + 1'b1;
            fired_next    = 1'b1;
            addr_next     = '0;
            best_any_next = 1'b0;
            state_next    = S_SCAN;
        end
    end

    always_comb
    begin
        o_id_next   = o_id_reg;
        o_st_next   = o_st_reg;
        o_last_next = o_last_reg;
        o_any_next  = o_any_reg;
        o_near_next = o_near_reg;
        if (load)
        begin
            o_id_next   = res_id_reg;
            o_st_next   = fired_reg ? ST_FIRED : res_st_reg;
            o_last_next = !more;
            o_any_next  = best_any_reg;
            o_near_next = best_any_reg ? FIELD_W'(best_val_reg) : '0;
        end
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        addr_reg     <= addr_next;
        idx_reg      <= idx_next;
        best_id_reg  <= best_id_next;
        best_val_reg <= best_val_next;
        count_reg    <= count_next;
        res_id_reg   <= res_id_next;
        res_st_reg   <= res_st_next;
        best_any_reg <= best_any_next;
        fired_reg    <= fired_next;
        o_id_reg     <= o_id_next;
        o_st_reg     <= o_st_next;
        o_last_reg   <= o_last_next;
        o_any_reg    <= o_any_next;
        o_near_reg   <= o_near_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign fired_id         = o_id_reg;
    assign status           = o_st_reg;
    assign last             = o_last_reg;
    assign any_armed        = o_any_reg;
    assign nearest_deadline = o_near_reg;

endmodule

`default_nettype wire

// ----- design/deadline_timer_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Arm, cancel, unused code: the result follows one full scan of the deadline RAM.
// Advance, nothing due: one scan; with fires the first result follows a second scan after the fire.
// Each further fire adds one rescan; an output stall holds the result and delays further fires.
// One item is carried out at a time; a two-item queue lets the front accept while the back works.
// Reset clears all armed flags at once; the deadline RAM needs no clearing pass.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic [ID_W-1:0]    timer_id,
    input  wire logic [FIELD_W-1:0] deadline,
    input  wire logic [FIELD_W-1:0] now_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ID_W-1:0]         fired_id,
    output logic [1:0]              status,
    output logic                    last,
    output logic                    any_armed,
    output logic [FIELD_W-1:0]      nearest_deadline
);

    // Queue between the classifier and the scan engine
    logic      q_valid;
    logic      q_pop;
    dtq_item_t q_item;

    // Front: hold incoming items, decode the command and range-check the slot
    dtq_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .timer_id (timer_id),
        .deadline (deadline),
        .now_time (now_time),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: update flags, scan for the earliest deadline, fire due timers in order
    dtq_back #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .fired_id         (fired_id),
        .status           (status),
        .last             (last),
        .any_armed        (any_armed),
        .nearest_deadline (nearest_deadline)
    );

endmodule

`default_nettype wire

// ----- design/dtq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtq_checker
    import dtq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [ID_W-1:0]    fired_id,
    input wire logic [1:0]         status,
    input wire logic               last,
    input wire logic               any_armed,
    input wire logic [FIELD_W-1:0] nearest_deadline
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired_id) && $stable(status)
            && $stable(last) && $stable(nearest_deadline))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_armed |-> nearest_deadline == '0)
        else $error("nearest deadline nonzero with nothing armed");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNARMED |-> last)
        else $error("cancel or range error result not final");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> status == ST_FIRED)
        else $error("non-final result that is not a fire");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

`default_nettype wire
